>>> rtl/rle_pkg.sv
// Package: shared types and constants of the run-length line encoder.
package rle_pkg;

   localparam logic [7:0]  LITERAL_FLAG    = 8'h80;
   localparam logic [7:0]  LINE_TERMINATOR = 8'h00;
   localparam logic [16:0] LEN_LIMIT       = 17'd131071;
   localparam logic [5:0]  MAX_RESULTS     = 6'd36;
   localparam int          STORE_DEPTH     = 128;
   localparam int          QUEUE_DEPTH     = 4;
   localparam int          QUEUE_AW        = 2;

   typedef enum logic [1:0] {
      CMD_LIT,
      CMD_RUN,
      CMD_FLUSH_LIT,
      CMD_TERM
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         step_first;
      logic [7:0]   value;
      logic [6:0]   count;
   } cmd_type;

   typedef struct packed {
      logic       a_valid;
      cmd_type    a;
      logic       b_valid;
      cmd_type    b;
      logic [6:0] rc;
      logic [7:0] rv;
      logic [6:0] lc;
   } take_result_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_TAKE,
      F_END0,
      F_END1,
      F_FLUSH,
      F_TERM
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_RUN_CNT,
      B_RUN_VAL,
      B_LIT_HDR,
      B_LIT_DATA,
      B_TERM
   } back_state_type;

endpackage

>>> rtl/rle_cmd_queue.sv
// Command queue between the classifying front and the emitting back.
module rle_cmd_queue import rle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0] rptr_ff, rptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff + QUEUE_AW'(push);
      rptr_in  = rptr_ff + QUEUE_AW'(pop);
      count_in = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_cmd;
   end

endmodule

>>> rtl/rle_front.sv
// Front end: lookahead, run/literal decisions, command generation.
module rle_front import rle_pkg::*; #(
   parameter int MAX_LITERAL = 127,
   parameter int MAX_RUN     = 126
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   output logic       cmd_push,
   output cmd_type    cmd,
   input  logic       q_full
);

   front_state_type state_ff, state_in;
   logic [7:0] x_ff, x_in;
   logic       end_ff, end_in;
   logic [7:0] la0_ff, la0_in, la1_ff, la1_in;
   logic [1:0] lav_ff, lav_in;
   logic [6:0] rc_ff, rc_in, lc_ff, lc_in;
   logic [7:0] rv_ff, rv_in;
   cmd_type    pend_ff, pend_in;
   logic       pend_valid_ff, pend_valid_in;
   logic       first_ff, first_in;

   logic            do_take, take_triple;
   logic [7:0]      take_x;
   take_result_type t;

   function automatic take_result_type take_byte(logic [7:0] x, logic triple,
         logic [6:0] rc, logic [7:0] rv, logic [6:0] lc);
      take_result_type r;
      logic            fall;
      logic [7:0]      rc_inc, lc_inc;
      r      = '0;
      r.rc   = rc;
      r.rv   = rv;
      r.lc   = lc;
      fall   = 1'b0;
      rc_inc = {1'b0, rc} + 8'd1;
      lc_inc = {1'b0, lc} + 8'd1;
      if (rc != '0) begin
         if (x == rv) begin
            if (rc_inc >= 8'(MAX_RUN)) begin
               r.a_valid = 1'b1;
               r.a.kind  = CMD_RUN;
               r.a.value = rv;
               r.a.count = rc_inc[6:0];
               r.rc      = '0;
            end else begin
               r.rc = rc_inc[6:0];
            end
         end else begin
            r.a_valid = 1'b1;
            r.a.kind  = CMD_RUN;
            r.a.value = rv;
            r.a.count = rc;
            r.rc      = '0;
            fall      = 1'b1;
         end
      end else if (lc != '0) begin
         if (!triple) begin
            r.a_valid = 1'b1;
            r.a.kind  = CMD_LIT;
            r.a.value = x;
            r.a.count = lc;
            if (lc_inc >= 8'(MAX_LITERAL)) begin
               r.b_valid = 1'b1;
               r.b.kind  = CMD_FLUSH_LIT;
               r.b.count = lc_inc[6:0];
               r.lc      = '0;
            end else begin
               r.lc = lc_inc[6:0];
            end
         end else begin
            r.a_valid = 1'b1;
            r.a.kind  = CMD_FLUSH_LIT;
            r.a.count = lc;
            r.lc      = '0;
            fall      = 1'b1;
         end
      end else begin
         fall = 1'b1;
      end
      if (fall) begin
         if (triple) begin
            r.rv = x;
            r.rc = 7'd1;
         end else begin
            if (!r.a_valid) begin
               r.a_valid = 1'b1;
               r.a.kind  = CMD_LIT;
               r.a.value = x;
               r.a.count = '0;
            end else begin
               r.b_valid = 1'b1;
               r.b.kind  = CMD_LIT;
               r.b.value = x;
               r.b.count = '0;
            end
            r.lc = 7'd1;
         end
      end
      return r;
   endfunction

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      end_in        = end_ff;
      la0_in        = la0_ff;
      la1_in        = la1_ff;
      lav_in        = lav_ff;
      rc_in         = rc_ff;
      rv_in         = rv_ff;
      lc_in         = lc_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      first_in      = first_ff;
      req_tready    = 1'b0;
      cmd_push      = 1'b0;
      cmd           = '0;
      do_take       = 1'b0;
      take_x        = la0_ff;
      take_triple   = 1'b0;
      if (pend_valid_ff) begin
         // drain the second command of the last decision first
         if (!q_full) begin
            cmd_push      = 1'b1;
            cmd           = pend_ff;
            pend_valid_in = 1'b0;
         end
      end else begin
         case (state_ff)
            F_IDLE: begin
               req_tready = 1'b1;
               if (req_tvalid) begin
                  x_in     = req_tdata;
                  end_in   = req_tlast;
                  first_in = 1'b1;
                  state_in = F_TAKE;
               end
            end
            F_TAKE: begin
               if (lav_ff == 2'd2) begin
                  if (!q_full) begin
                     do_take     = 1'b1;
                     take_x      = la0_ff;
                     take_triple = (la1_ff == la0_ff) && (x_ff == la0_ff);
                     la0_in      = la1_ff;
                     la1_in      = x_ff;
                     state_in    = end_ff ? F_END0 : F_IDLE;
                  end
               end else begin
                  if (lav_ff == 2'd0) la0_in = x_ff;
                  else la1_in = x_ff;
                  lav_in   = lav_ff + 2'd1;
                  state_in = end_ff ? F_END0 : F_IDLE;
               end
            end
            F_END0: begin
               if (!q_full) begin
                  do_take  = 1'b1;
                  take_x   = la0_ff;
                  state_in = (lav_ff == 2'd2) ? F_END1 : F_FLUSH;
               end
            end
            F_END1: begin
               if (!q_full) begin
                  do_take  = 1'b1;
                  take_x   = la1_ff;
                  state_in = F_FLUSH;
               end
            end
            F_FLUSH: begin
               if (!q_full) begin
                  if (rc_ff != '0) begin
                     cmd_push       = 1'b1;
                     cmd.kind       = CMD_RUN;
                     cmd.value      = rv_ff;
                     cmd.count      = rc_ff;
                     cmd.step_first = first_ff;
                     first_in       = 1'b0;
                     rc_in          = '0;
                  end else if (lc_ff != '0) begin
                     cmd_push       = 1'b1;
                     cmd.kind       = CMD_FLUSH_LIT;
                     cmd.count      = lc_ff;
                     cmd.step_first = first_ff;
                     first_in       = 1'b0;
                     lc_in          = '0;
                  end
                  state_in = F_TERM;
               end
            end
            F_TERM: begin
               if (!q_full) begin
                  cmd_push       = 1'b1;
                  cmd.kind       = CMD_TERM;
                  cmd.step_first = first_ff;
                  first_in       = 1'b0;
                  lav_in         = '0;
                  state_in       = F_IDLE;
               end
            end
            default: state_in = F_IDLE;
         endcase
      end
      t = take_byte(take_x, take_triple, rc_ff, rv_ff, lc_ff);
      if (do_take) begin
         rc_in = t.rc;
         rv_in = t.rv;
         lc_in = t.lc;
         if (t.a_valid) begin
            cmd_push       = 1'b1;
            cmd            = t.a;
            cmd.step_first = first_ff;
            first_in       = 1'b0;
         end
         if (t.b_valid) begin
            pend_in       = t.b;
            pend_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         lav_ff        <= '0;
         rc_ff         <= '0;
         rv_ff         <= '0;
         lc_ff         <= '0;
         pend_valid_ff <= 1'b0;
         first_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lav_ff        <= lav_in;
         rc_ff         <= rc_in;
         rv_ff         <= rv_in;
         lc_ff         <= lc_in;
         pend_valid_ff <= pend_valid_in;
         first_ff      <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      end_ff  <= end_in;
      la0_ff  <= la0_in;
      la1_ff  <= la1_in;
      pend_ff <= pend_in;
   end

endmodule

>>> rtl/rle_back.sv
// Back end: literal store, byte emission, packing and the result register.
module rle_back import rle_pkg::*; #(
   parameter int BYTES_PER_RESULT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     head,
   input  logic        q_empty,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast
);

   back_state_type state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [7:0]  val_ff, val_in;
   logic [6:0]  ridx_ff, ridx_in;
   logic [7:0]  rdata_ff;
   logic [7:0]  store [STORE_DEPTH];
   logic [7:0]  pack_ff [BYTES_PER_RESULT];
   logic [3:0]  fill_ff, fill_in;
   logic [16:0] len_ff, len_in;
   logic [5:0]  resn_ff, resn_in;
   logic        ov_ff, ov_in;
   logic [31:0] obytes_ff, obytes_in;
   logic [2:0]  ocnt_ff, ocnt_in;
   logic        olast_ff, olast_in;
   logic [16:0] olen_ff, olen_in;

   logic        emit_req, emit_go, elast, mk_res, drop, out_free, rd_en;
   logic [7:0]  ebyte;
   logic [6:0]  rd_addr;
   logic [3:0]  fill_inc;
   logic [16:0] len_new;
   logic [63:0] word;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      val_in    = val_ff;
      ridx_in   = ridx_ff;
      resn_in   = resn_ff;
      pop       = 1'b0;
      emit_req  = 1'b0;
      ebyte     = LINE_TERMINATOR;
      elast     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = ridx_ff;
      out_free  = !ov_ff || rsp_tready;
      fill_inc  = fill_ff + 4'd1;
      drop      = (resn_ff >= MAX_RESULTS);
      len_new   = (len_ff == LEN_LIMIT) ? len_ff : len_ff + 17'd1;
      case (state_ff)
         B_RUN_CNT:  begin emit_req = 1'b1; ebyte = {1'b0, cnt_ff}; end
         B_RUN_VAL:  begin emit_req = 1'b1; ebyte = val_ff; end
         B_LIT_HDR:  begin emit_req = 1'b1; ebyte = LITERAL_FLAG | {1'b0, cnt_ff}; end
         B_LIT_DATA: begin emit_req = 1'b1; ebyte = rdata_ff; end
         B_TERM:     begin emit_req = 1'b1; elast = 1'b1; end
         default:    emit_req = 1'b0;
      endcase
      mk_res  = (fill_inc >= 4'(BYTES_PER_RESULT)) || elast;
      emit_go = emit_req && (!mk_res || drop || out_free);
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               if (head.step_first) resn_in = '0;
               cnt_in = head.count;
               val_in = head.value;
               case (head.kind)
                  CMD_RUN:       state_in = B_RUN_CNT;
                  CMD_FLUSH_LIT: state_in = B_LIT_HDR;
                  CMD_TERM:      state_in = B_TERM;
                  default:       state_in = B_IDLE;
               endcase
            end
         end
         B_RUN_CNT: if (emit_go) state_in = B_RUN_VAL;
         B_RUN_VAL: if (emit_go) state_in = B_IDLE;
         B_LIT_HDR: begin
            if (emit_go) begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               ridx_in  = 7'd1;
               state_in = B_LIT_DATA;
            end
         end
         B_LIT_DATA: begin
            if (emit_go) begin
               if (ridx_ff == cnt_ff) begin
                  state_in = B_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  ridx_in = ridx_ff + 7'd1;
               end
            end
         end
         B_TERM:  if (emit_go) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase

      word = '0;
      for (int i = 0; i < BYTES_PER_RESULT; i++) begin
         if (4'(i) < fill_ff) word[8*i +: 8] = pack_ff[i];
         else if (4'(i) == fill_ff) word[8*i +: 8] = ebyte;
      end

      fill_in   = fill_ff;
      len_in    = len_ff;
      ov_in     = ov_ff && !rsp_tready;
      obytes_in = obytes_ff;
      ocnt_in   = ocnt_ff;
      olast_in  = olast_ff;
      olen_in   = olen_ff;
      if (emit_go) begin
         len_in  = elast ? '0 : len_new;
         fill_in = mk_res ? '0 : fill_inc;
         if (mk_res) begin
            if (!drop) begin
               resn_in   = resn_ff + 6'd1;
               ov_in     = 1'b1;
               obytes_in = word[31:0];
               ocnt_in   = fill_inc[2:0];
               olast_in  = elast;
               olen_in   = elast ? len_new : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         fill_ff  <= '0;
         len_ff   <= '0;
         resn_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         resn_ff  <= resn_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      val_ff    <= val_in;
      ridx_ff   <= ridx_in;
      obytes_ff <= obytes_in;
      ocnt_ff   <= ocnt_in;
      olast_ff  <= olast_in;
      olen_ff   <= olen_in;
      if (pop && head.kind == CMD_LIT) store[head.count] <= head.value;
      if (rd_en) rdata_ff <= store[rd_addr];
      for (int i = 0; i < BYTES_PER_RESULT; i++) begin
         if (emit_go && 4'(i) == fill_ff) pack_ff[i] <= ebyte;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {4'b0, olen_ff, ocnt_ff, obytes_ff};

endmodule

>>> rtl/rle_line_encoder_unit.sv
// Top level: run-length line encoder with decoupled front and back ends.
// Input: a byte is accepted (F_IDLE), then decided (F_TAKE); a two-command decision
// also drains its pending command; a line end adds F_END0, F_END1 (not on a one-byte
// line), F_FLUSH, F_TERM. Output: at most one coded byte per cycle, stalled while a
// result awaits rsp_tready; an n-byte literal is n store writes, header, n reads.
// Reset clears all control state; the literal store holds no reset value.
module rle_line_encoder_unit import rle_pkg::*; #(
   parameter int MAX_LITERAL      = 127,
   parameter int MAX_RUN          = 126,
   parameter int BYTES_PER_RESULT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // raw_byte
   input  logic        req_tlast,   // line_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // packed_bytes[31:0], byte_count[34:32],
                                    // coded_length[51:35], zero pad
   output logic        rsp_tlast    // line_done
);

   cmd_type q_in_cmd, q_head;
   logic    q_push, q_pop, q_full, q_empty;

   rle_front #(
      .MAX_LITERAL(MAX_LITERAL),
      .MAX_RUN    (MAX_RUN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .cmd_push  (q_push),
      .cmd       (q_in_cmd),
      .q_full    (q_full)
   );

   rle_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_cmd(q_in_cmd),
      .pop     (q_pop),
      .head    (q_head),
      .full    (q_full),
      .empty   (q_empty)
   );

   rle_back #(
      .BYTES_PER_RESULT(BYTES_PER_RESULT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .pop       (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("command pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("command popped from empty queue");

   a_len_zero_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[51:35] == 17'd0)
      else $error("coded length set on a result without line_done");

   a_len_set_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[51:35] != 17'd0)
      else $error("coded length missing on line_done result");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for rle_line_encoder_unit: directed table and random lines.
module tb_top import rle_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIT_MAX   = 127;
   localparam int RUN_MAX   = 126;
   localparam int PACK_N    = 4;
   localparam int STEP_CAP  = 36;
   localparam int LEN_SAT   = 131071;
   localparam int ITEM_N    = 270;
   localparam int CYCLE_CAP = 500000;

   typedef struct {
      logic [31:0] packed_bytes;
      logic [2:0]  byte_count;
      logic        line_done;
      logic [16:0] coded_length;
   } coded_word_type;

   typedef struct {
      logic [7:0]  raw;
      logic        eol;
      logic        typed;
      logic [31:0] word;
      logic [2:0]  cnt;
      logic [16:0] len;
   } table_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;   // raw_byte
   logic        req_tlast = 0;   // line_end
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;       // packed_bytes, byte_count, coded_length, pad
   logic        rsp_tlast;       // line_done

   rle_line_encoder_unit dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // encoder state mirror
   logic [7:0] lit_mem [128];
   int         lit_n, run_n, ahead_n, pack_n, line_len, step_words;
   logic [7:0] run_byte;
   logic [7:0] ahead [2];
   logic [7:0] pack_buf [PACK_N];
   coded_word_type step_q[$];
   coded_word_type coded_q[$];

   int errors = 0, cycles = 0, items_in = 0, words_out = 0, lines_in = 0, max_len = 0;
   int burst_left = 0;
   bit hold_done = 0;

   function automatic void emit_word(bit last);
      coded_word_type w;
      w.packed_bytes = '0;
      for (int i = 0; i < pack_n; i++) w.packed_bytes[8*i +: 8] = pack_buf[i];
      w.byte_count   = pack_n[2:0];
      w.line_done    = last;
      w.coded_length = last ? line_len[16:0] : '0;
      if (step_words < STEP_CAP) begin
         step_q.push_back(w);
         step_words++;
      end
      pack_n = 0;
   endfunction

   function automatic void emit_byte(logic [7:0] b, bit last);
      if (line_len < LEN_SAT) line_len++;
      pack_buf[pack_n] = b;
      pack_n++;
      if (pack_n >= PACK_N || last) emit_word(last);
   endfunction

   function automatic void close_run();
      emit_byte(run_n[7:0], 0);
      emit_byte(run_byte, 0);
      run_n = 0;
   endfunction

   function automatic void close_literal();
      emit_byte(LITERAL_FLAG | lit_n[7:0], 0);
      for (int i = 0; i < lit_n; i++) emit_byte(lit_mem[i], 0);
      lit_n = 0;
   endfunction

   function automatic void code_byte(logic [7:0] x, bit h1, logic [7:0] n1, bit h2,
                                     logic [7:0] n2);
      bit triple;
      triple = h1 && h2 && n1 == x && n2 == x;
      if (run_n > 0) begin
         if (x == run_byte) begin
            run_n++;
            if (run_n >= RUN_MAX) close_run();
            return;
         end
         close_run();
      end else if (lit_n > 0) begin
         if (!triple) begin
            lit_mem[lit_n] = x;
            lit_n++;
            if (lit_n >= LIT_MAX) close_literal();
            return;
         end
         close_literal();
      end
      if (triple) begin
         run_byte = x;
         run_n    = 1;
      end else begin
         lit_mem[0] = x;
         lit_n      = 1;
      end
   endfunction

   // leaves this transaction's expected words in step_q
   function automatic void encode_step(logic [7:0] x, bit eol);
      logic [7:0] q [4];
      int v;
      step_q.delete();
      step_words = 0;
      if (ahead_n >= 2) begin
         code_byte(ahead[0], 1, ahead[1], 1, x);
         ahead[0] = ahead[1];
         ahead[1] = x;
      end else begin
         ahead[ahead_n] = x;
         ahead_n++;
      end
      if (eol) begin
         q = '{ahead[0], ahead[1], 8'h00, 8'h00};
         v = ahead_n;
         for (int i = 0; i < v; i++)
            code_byte(q[i], i + 1 < v, q[i+1], i + 2 < v, q[i+2]);
         ahead_n = 0;
         if (run_n > 0) close_run();
         if (lit_n > 0) close_literal();
         emit_byte(LINE_TERMINATOR, 1);
         line_len = 0;
      end
   endfunction

   task automatic send_byte(logic [7:0] b, bit eol, bit gaps);
      if (gaps && burst_left == 0) begin
         int gap;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1;
      req_tdata  <= b;
      req_tlast  <= eol;
      do @(posedge clock); while (!req_tready);
      items_in++;
      if (eol) lines_in++;
      encode_step(b, eol);
   endtask

   task automatic send_random_line(int n);
      logic [7:0] prev;
      int k, seg;
      logic [7:0] b;
      prev = 8'($urandom);
      k = 0;
      while (k < n) begin
         case ($urandom_range(0, 3))
            0: seg = $urandom_range(1, 5);
            1: seg = ($urandom_range(0, 5) == 0) ? $urandom_range(120, 140)
                                                 : $urandom_range(2, 9);
            default: seg = 1;
         endcase
         b = ($urandom_range(0, 2) == 0) ? prev : 8'($urandom);
         for (int j = 0; j < seg && k < n; j++) begin
            send_byte(b, k == n - 1, 1);
            coded_q = {coded_q, step_q};
            k++;
         end
         prev = b;
      end
   endtask

   // receiver: compare each transaction with the oldest expectation
   always @(posedge clock) begin
      int mode_left, mode, hold_left;
      coded_word_type e;
      if (!reset) begin
         cycles++;
         if (cycles > CYCLE_CAP) begin
            $display("%0t timeout with %0d words outstanding", $time, coded_q.size());
            $display("Verification failed");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            words_out++;
            if (coded_q.size() == 0) begin
               $display("%0t unexpected word: expected none, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               e = coded_q.pop_front();
               if (rsp_tdata[31:0] !== e.packed_bytes || rsp_tdata[34:32] !== e.byte_count ||
                   rsp_tlast !== e.line_done || rsp_tdata[51:35] !== e.coded_length) begin
                  $display("%0t mismatch: expected bytes %h cnt %0d done %0b len %0d",
                           $time, e.packed_bytes, e.byte_count, e.line_done, e.coded_length);
                  $display("%0t            actual bytes %h cnt %0d done %0b len %0d",
                           $time, rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast,
                           rsp_tdata[51:35]);
                  errors++;
               end
               if (e.line_done && e.coded_length > max_len) max_len = e.coded_length;
            end
         end
         // hold off once for a long stretch so the input side backs up
         if (!hold_done && items_in >= 120) begin
            hold_done = 1;
            hold_left = 400;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else
            rsp_tready <= (mode == 0) || (mode == 1 && $urandom_range(0, 1) == 1) ||
                          (mode == 2 && $urandom_range(0, 3) == 0);
      end
   end

   table_row_type dir_table [] = '{
      '{8'h00, 1, 1, 32'h0000_0081, 3'd3, 17'd3},
      '{8'hFF, 1, 1, 32'h0000_FF81, 3'd3, 17'd3},
      '{8'h5A, 1, 1, 32'h0000_5A81, 3'd3, 17'd3},
      '{8'h07, 0, 0, 0, 0, 0},
      '{8'h07, 0, 0, 0, 0, 0},
      '{8'h07, 1, 1, 32'h0000_0703, 3'd3, 17'd3},
      '{8'h01, 0, 0, 0, 0, 0},
      '{8'h02, 1, 1, 32'h0002_0182, 3'd4, 17'd4},
      '{8'h10, 0, 0, 0, 0, 0},
      '{8'h20, 0, 0, 0, 0, 0},
      '{8'h20, 0, 0, 0, 0, 0},
      '{8'h20, 0, 0, 0, 0, 0},
      '{8'h20, 0, 0, 0, 0, 0},
      '{8'h30, 1, 0, 0, 0, 0},
      '{8'h55, 0, 0, 0, 0, 0},
      '{8'hAA, 0, 0, 0, 0, 0},
      '{8'h55, 0, 0, 0, 0, 0},
      '{8'hAA, 0, 0, 0, 0, 0},
      '{8'h55, 1, 0, 0, 0, 0},
      '{8'hC3, 0, 0, 0, 0, 0},
      '{8'hC3, 1, 0, 0, 0, 0},
      '{8'h3C, 0, 0, 0, 0, 0},
      '{8'h3C, 0, 0, 0, 0, 0},
      '{8'h3C, 0, 0, 0, 0, 0},
      '{8'h3C, 1, 0, 0, 0, 0}
   };

   initial begin
      coded_word_type t;
      int n;
      lit_n = 0; run_n = 0; ahead_n = 0; pack_n = 0; line_len = 0; run_byte = 0;
      ahead = '{8'h00, 8'h00};
      repeat (5) @(posedge clock);
      reset <= 0;

      foreach (dir_table[i]) begin
         send_byte(dir_table[i].raw, dir_table[i].eol, 1);
         if (dir_table[i].typed) begin
            t = '{dir_table[i].word, dir_table[i].cnt, 1'b1, dir_table[i].len};
            coded_q.push_back(t);
         end else
            coded_q = {coded_q, step_q};
      end

      // random lines, mostly short, a few long enough to carry long runs
      while (items_in < ITEM_N) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(130, 300) : $urandom_range(1, 12);
         if (n > ITEM_N - items_in) n = ITEM_N - items_in;
         send_random_line(n);
      end
      req_tvalid <= 0;

      wait (coded_q.size() == 0);
      repeat (100) @(posedge clock);
      $display("Sent %0d bytes in %0d lines, checked %0d coded words, longest line %0d bytes",
               items_in, lines_in, words_out, max_len);
      if (errors == 0 && coded_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
